### hw/rtl/awm_pkg.sv
// Shared types and constants for the sliding-window anagram matcher.
// Used by every module under hw/rtl except awm_checker; depends on nothing.
package awm_pkg;

  localparam int SYM_W     = 8;
  localparam int TBL_DEPTH = 256;
  // Signed count of pattern minus window occurrences; covers +/-255.
  localparam int CNT_W     = 9;
  localparam int IDX_W     = 32;

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;

  typedef struct packed {
    logic                    in_pat;
    logic signed [CNT_W-1:0] count;
  } cnt_entry_t;

  typedef struct packed {
    logic             we;
    logic [SYM_W-1:0] wr_addr;
    cnt_entry_t       wr_data;
    logic [SYM_W-1:0] rd_addr;
  } tbl_req_t;

  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_t;

  typedef struct packed {
    logic             match;
    logic [IDX_W-1:0] start_index;
    logic             rejected;
  } result_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PAT_RD,
    ST_PAT_WR,
    ST_TXT_RD,
    ST_TXT_WR,
    ST_LV_RD,
    ST_LV_WR,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/awm_count_table.sv
// Symbol count and pattern-membership table, one entry per byte value.
// Single write port, one registered read port. Depends on awm_pkg.
module awm_count_table
  import awm_pkg::*;
(
  input  logic       clk,
  input  tbl_req_t   req,
  output cnt_entry_t rd_data
);

  cnt_entry_t mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

### hw/rtl/awm_window_ring.sv
// Ring of the most recent text bytes, used to find the byte leaving the window.
// Single write port, one registered read port. Depends on awm_pkg.
module awm_window_ring
  import awm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SYM_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [SYM_W-1:0] rd_data
);

  logic [SYM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/awm_count_alu.sv
// Shared increment/decrement unit for count table entries.
// Combinational; depends on awm_pkg.
module awm_count_alu
  import awm_pkg::*;
(
  input  logic signed [CNT_W-1:0] operand,
  input  alu_op_t                 op,
  output logic signed [CNT_W-1:0] sum,
  output logic                    was_zero,
  output logic                    now_zero
);

  always_comb begin
    sum      = (op == ALU_DEC) ? operand - CNT_W'(1) : operand + CNT_W'(1);
    was_zero = (operand == '0);
    now_zero = (sum == '0);
  end

endmodule

### hw/rtl/awm_core.sv
// Sequencer and datapath of the matcher: walks each word through table
// read-modify-write steps on the shared count unit. Depends on awm_pkg,
// awm_count_table, awm_window_ring and awm_count_alu.
module awm_core
  import awm_pkg::*;
#(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req,
  input  logic [SYM_W-1:0] in_sym,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int PSW = $clog2(PATTERN_MAX + 1);
  localparam int RAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  state_t state, state_next;

  logic [SYM_W-1:0]         sweep_addr, sweep_addr_next;
  logic                     clr_reply, clr_reply_next;
  logic [SYM_W-1:0]         sym_q, sym_q_next;
  logic [SYM_W-1:0]         leave_q, leave_q_next;
  logic [PSW-1:0]           distinct, distinct_next;
  logic [PSW-1:0]           matched, matched_next;
  logic [PSW-1:0]           pattern_size, pattern_size_next;
  logic [RAW-1:0]           head, head_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] wbegin, wbegin_next;
  logic                     started, started_next;
  result_t                  res_q, res_q_next;

  tbl_req_t                 tbl_req;
  cnt_entry_t               tbl_rd;
  logic                     ring_we;
  logic [RAW-1:0]           ring_rd_addr;
  logic [SYM_W-1:0]         ring_rd;

  alu_op_t                  alu_op;
  logic signed [CNT_W-1:0]  alu_sum;
  logic                     alu_was_zero, alu_now_zero;

  logic                     accept;
  logic                     pat_block;
  logic                     slide;
  logic [PSW:0]             back, head_ext, idx_wide;
  logic [PSW-1:0]           matched_dec;
  logic [SYM_W-1:0]         leave_sym;
  logic [POSITION_BITS+IDX_W-1:0] begin_ext;

  awm_count_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  awm_window_ring #(
    .DEPTH (PATTERN_MAX),
    .AW    (RAW)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .wr_addr (head),
    .wr_data (sym_q),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd)
  );

  awm_count_alu u_alu (
    .operand  (tbl_rd.count),
    .op       (alu_op),
    .sum      (alu_sum),
    .was_zero (alu_was_zero),
    .now_zero (alu_now_zero)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_q;
  assign pat_block = started || (pattern_size >= PSW'(PATTERN_MAX));
  assign slide     = (pattern_size != '0) &&
                     (pos >= POSITION_BITS'(pattern_size - 1'b1));
  assign begin_ext = {{IDX_W{1'b0}}, wbegin};

  // Ring slot of the oldest byte in the window: head minus (size - 1), wrapped.
  always_comb begin
    back     = (PSW + 1)'(pattern_size) - 1'b1;
    head_ext = (PSW + 1)'(head);
    if (head_ext >= back) begin
      idx_wide = head_ext - back;
    end else begin
      idx_wide = head_ext + (PSW + 1)'(PATTERN_MAX) - back;
    end
    ring_rd_addr = idx_wide[RAW-1:0];
  end

  // With a one-byte pattern the leaving byte is the one just written.
  assign leave_sym   = (pattern_size == PSW'(1)) ? sym_q : ring_rd;
  assign matched_dec = matched + PSW'(tbl_rd.in_pat && alu_now_zero);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_addr == SYM_W'(TBL_DEPTH - 1)) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req)
            REQ_CLEAR:   state_next = ST_SWEEP;
            REQ_PATTERN: state_next = pat_block ? ST_DONE : ST_PAT_RD;
            REQ_TEXT:    state_next = ST_TXT_RD;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_PAT_RD: state_next = ST_PAT_WR;
      ST_PAT_WR: state_next = ST_DONE;
      ST_TXT_RD: state_next = ST_TXT_WR;
      ST_TXT_WR: state_next = slide ? ST_LV_RD : ST_DONE;
      ST_LV_RD:  state_next = ST_LV_WR;
      ST_LV_WR:  state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_SWEEP;
    endcase
  end

  // Memory ports and shared unit control
  always_comb begin
    tbl_req         = '0;
    tbl_req.rd_addr = sym_q;
    ring_we         = 1'b0;
    alu_op          = ALU_INC;
    case (state)
      ST_SWEEP: begin
        tbl_req.we      = 1'b1;
        tbl_req.wr_addr = sweep_addr;
      end
      ST_PAT_WR: begin
        tbl_req.we      = 1'b1;
        tbl_req.wr_addr = sym_q;
        tbl_req.wr_data = '{in_pat: 1'b1, count: alu_sum};
      end
      ST_TXT_WR: begin
        alu_op          = ALU_DEC;
        tbl_req.we      = tbl_rd.in_pat;
        tbl_req.wr_addr = sym_q;
        tbl_req.wr_data = '{in_pat: 1'b1, count: alu_sum};
        ring_we         = 1'b1;
      end
      ST_LV_RD: begin
        tbl_req.rd_addr = leave_q;
      end
      ST_LV_WR: begin
        tbl_req.we      = tbl_rd.in_pat;
        tbl_req.wr_addr = leave_q;
        tbl_req.wr_data = '{in_pat: 1'b1, count: alu_sum};
      end
      default: begin
      end
    endcase
  end

  // Datapath register next values
  always_comb begin
    sweep_addr_next   = sweep_addr;
    clr_reply_next    = clr_reply;
    sym_q_next        = sym_q;
    leave_q_next      = leave_q;
    distinct_next     = distinct;
    matched_next      = matched;
    pattern_size_next = pattern_size;
    head_next         = head;
    pos_next          = pos;
    wbegin_next       = wbegin;
    started_next      = started;
    res_q_next        = res_q;
    case (state)
      ST_SWEEP: begin
        sweep_addr_next = sweep_addr + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          sym_q_next = in_sym;
          res_q_next = '0;
          if (in_req == REQ_CLEAR) begin
            sweep_addr_next   = '0;
            clr_reply_next    = 1'b1;
            distinct_next     = '0;
            matched_next      = '0;
            pattern_size_next = '0;
            head_next         = '0;
            pos_next          = '0;
            wbegin_next       = '0;
            started_next      = 1'b0;
          end else if (in_req == REQ_PATTERN) begin
            res_q_next.rejected = pat_block;
          end
        end
      end
      ST_PAT_WR: begin
        if (!tbl_rd.in_pat) begin
          distinct_next = distinct + 1'b1;
        end
        pattern_size_next = pattern_size + 1'b1;
      end
      ST_TXT_WR: begin
        started_next = 1'b1;
        matched_next = matched_dec;
        if (matched_dec == distinct) begin
          res_q_next.match       = 1'b1;
          res_q_next.start_index = begin_ext[IDX_W-1:0];
        end
        if (slide) begin
          leave_q_next = leave_sym;
          wbegin_next  = (wbegin == '1) ? wbegin : wbegin + 1'b1;
        end
        head_next = (head == RAW'(PATTERN_MAX - 1)) ? '0 : head + 1'b1;
        pos_next  = (pos == '1) ? pos : pos + 1'b1;
      end
      ST_LV_WR: begin
        if (tbl_rd.in_pat && alu_was_zero) begin
          matched_next = matched - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      clr_reply    <= 1'b0;
      distinct     <= '0;
      matched      <= '0;
      pattern_size <= '0;
      head         <= '0;
      pos          <= '0;
      wbegin       <= '0;
      started      <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_addr   <= sweep_addr_next;
      clr_reply    <= clr_reply_next;
      distinct     <= distinct_next;
      matched      <= matched_next;
      pattern_size <= pattern_size_next;
      head         <= head_next;
      pos          <= pos_next;
      wbegin       <= wbegin_next;
      started      <= started_next;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    sym_q   <= sym_q_next;
    leave_q <= leave_q_next;
    res_q   <= res_q_next;
  end

endmodule

### hw/rtl/anagram_window_matcher.sv
// Top level of the sliding-window anagram matcher: sequencer core plus
// output register. Depends on awm_pkg and awm_core.
//
//   channel   dir  tdata             tuser
//   s_axis    in   [7:0] symbol      [1:0] req_type
//   m_axis    out  [31:0] start_idx  [0] match, [1] rejected
//
// The table read is registered, so each table update is a read state then a
// write state; a text byte makes a second update once the window slides, a clear
// word reruns the clearing pass, and a rejected pattern byte or unused code goes
// straight to its result. Each result reaches m_axis in the same cycle that
// s_axis_tready returns. Reset runs a clearing pass over the count table;
// s_axis_tready stays low until it finishes. A held result in the output
// register does not block accepting the next word; the core waits only when that word is done.
module anagram_window_matcher
  import awm_pkg::*;
#(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] start_index
  output logic [1:0]  m_axis_tuser    // [0] match, [1] rejected
);

  logic    res_valid, res_ready;
  result_t res;

  awm_core #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (s_axis_tuser),
    .in_sym    (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  // Load a new word only when the slot is free or draining.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res.start_index;
      m_axis_tuser <= {res.rejected, res.match};
    end
  end

endmodule

### hw/rtl/awm_checker.sv
// Port-level checks for anagram_window_matcher, bound to the top level.
// Depends only on the top-level ports.
module awm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_match_xor_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("match and rejected both set");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("start index nonzero without match");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or valid right after reset");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### sim/tb_anagram_window_matcher.sv
// Self-checking bench for anagram_window_matcher: drives clear, pattern and text words
// over the stream ports and checks every result against a built-in window model.
// Depends on awm_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module tb_anagram_window_matcher;
  import awm_pkg::*;

  localparam int         PAT_CAP    = 64;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] sym;
  } search_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] start_index
  logic [1:0]  m_axis_tuser;        // [0] match, [1] rejected

  anagram_window_matcher #(
    .PATTERN_MAX  (PAT_CAP),
    .POSITION_BITS(32)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  search_word_t pending_words[$];
  result_t      expected_results[$];
  search_word_t in_flight;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;
  int           fail_count = 0;
  int           words_accepted = 0;
  int           ignored_words = 0;
  int           results_checked = 0;
  int           match_count = 0;
  int           reject_count = 0;

  // Window model state
  int          pat_count[256];
  bit          pat_member[256];
  int unsigned distinct_syms;
  int unsigned matched_syms;
  int unsigned pat_len;
  logic [7:0]  win_ring[PAT_CAP];
  int unsigned ring_head;
  logic [31:0] text_pos;
  logic [31:0] win_begin;
  bit          text_seen;

  function automatic void clear_window_model();
    for (int i = 0; i < 256; i++) begin
      pat_count[i]  = 0;
      pat_member[i] = 1'b0;
    end
    for (int i = 0; i < PAT_CAP; i++) win_ring[i] = '0;
    distinct_syms = 0;
    matched_syms  = 0;
    pat_len       = 0;
    ring_head     = 0;
    text_pos      = '0;
    win_begin     = '0;
    text_seen     = 1'b0;
  endfunction

  function automatic result_t predict_window_result(input search_word_t w);
    result_t     r;
    int unsigned back;
    logic [7:0]  leave;
    r = '0;
    case (w.req)
      REQ_CLEAR: clear_window_model();
      REQ_PATTERN: begin
        if (text_seen || pat_len >= PAT_CAP) begin
          r.rejected = 1'b1;
        end else begin
          if (!pat_member[w.sym]) begin
            pat_member[w.sym] = 1'b1;
            distinct_syms++;
          end
          pat_count[w.sym]++;
          pat_len++;
        end
      end
      REQ_TEXT: begin
        text_seen = 1'b1;
        if (pat_member[w.sym]) begin
          pat_count[w.sym]--;
          if (pat_count[w.sym] == 0) matched_syms++;
        end
        if (matched_syms == distinct_syms) begin
          r.match       = 1'b1;
          r.start_index = win_begin;
        end
        win_ring[ring_head] = w.sym;
        // Slide once the window is full: re-add the byte that falls out
        if (pat_len > 0 && text_pos >= 32'(pat_len - 1)) begin
          back  = (ring_head + PAT_CAP - (pat_len - 1)) % PAT_CAP;
          leave = win_ring[back];
          if (win_begin != '1) win_begin++;
          if (pat_member[leave]) begin
            if (pat_count[leave] == 0) matched_syms--;
            pat_count[leave]++;
          end
        end
        ring_head = (ring_head + 1) % PAT_CAP;
        if (text_pos != '1) text_pos++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_word(input logic [1:0] req, input logic [7:0] sym);
    search_word_t w;
    w.req = req;
    w.sym = sym;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Mostly well-formed runs: clear, pattern, then text drawn from shuffled
  // copies of the pattern so windows line up; some runs skip the clear,
  // overfill the pattern, or carry stray words.
  task automatic queue_random_runs(input int target);
    int          made;
    int          plen;
    int          tlen;
    int          k;
    int          j;
    logic [7:0]  alpha[4];
    logic [7:0]  pat[$];
    logic [7:0]  deck[$];
    logic [7:0]  sym;
    logic [7:0]  tmp;
    made = 0;
    while (made < target) begin
      pat.delete();
      deck.delete();
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom);
      if ($urandom_range(99) < 85) begin
        push_word(REQ_CLEAR, 8'($urandom));
        made++;
      end
      k = $urandom_range(99);
      if (k < 8)       plen = 0;
      else if (k < 18) plen = PAT_CAP + $urandom_range(1, 3);
      else             plen = $urandom_range(1, 8);
      for (k = 0; k < plen; k++) begin
        sym = alpha[$urandom_range(3)];
        if (pat.size() < PAT_CAP) pat.insert(pat.size(), sym);
        push_word(REQ_PATTERN, sym);
        made++;
      end
      tlen = pat.size() + $urandom_range(4, 40);
      for (k = 0; k < tlen; k++) begin
        if (pat.size() == 0 || $urandom_range(99) < 15) begin
          sym = $urandom_range(1) ? alpha[$urandom_range(3)] : 8'($urandom);
        end else begin
          if (deck.size() == 0) begin
            deck = pat;
            for (j = deck.size() - 1; j > 0; j--) begin
              int p;
              p       = $urandom_range(j);
              tmp     = deck[j];
              deck[j] = deck[p];
              deck[p] = tmp;
            end
          end
          sym = deck.pop_front();
        end
        push_word(REQ_TEXT, sym);
        made++;
        j = $urandom_range(99);
        if (j < 4) begin
          push_word(REQ_PATTERN, 8'($urandom));
          made++;
        end else if (j < 6) begin
          push_word(REQ_UNUSED, 8'($urandom));
        end
      end
    end
  endtask

  // Driver: hold a word until taken, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(), predict_window_result(in_flight));
        words_accepted++;
        if (in_flight.req == REQ_UNUSED) ignored_words++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_flight = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= in_flight.sym;
          s_axis_tuser  <= in_flight.req;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no prediction pending: tdata=%h tuser=%b",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          result_t want;
          want = expected_results.pop_front();
          results_checked++;
          if (m_axis_tuser[0] !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tdata !== want.start_index) begin
            $error("start_index: expected %0d, got %0d", want.start_index, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[1] !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, m_axis_tuser[1]);
            fail_count++;
          end
          if (want.match) match_count++;
          if (want.rejected) reject_count++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5000000;
    $display("tb_anagram_window_matcher failed");
    $finish;
  end

  initial begin
    clear_window_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 38 : (phase == 1) ? 84 : 0;
      recv_stall_pct = (phase == 0) ? 84 : (phase == 1) ? 38 : 0;
      if (phase == 0) begin
        // Empty pattern matches at start 0, then a late pattern byte and stray code
        push_word(REQ_TEXT, 8'h00);
        push_word(REQ_TEXT, 8'hFF);
        push_word(REQ_PATTERN, 8'h41);
        push_word(REQ_UNUSED, 8'hAA);
        push_word(REQ_CLEAR, 8'h5A);
        push_word(REQ_PATTERN, 8'h00);
        push_word(REQ_PATTERN, 8'hFF);
        push_word(REQ_PATTERN, 8'h00);
        push_word(REQ_TEXT, 8'hFF);
        push_word(REQ_TEXT, 8'h00);
        push_word(REQ_TEXT, 8'h00);
        push_word(REQ_TEXT, 8'hFF);
        push_word(REQ_TEXT, 8'h12);
        push_word(REQ_TEXT, 8'h00);
        push_word(REQ_TEXT, 8'hFF);
        push_word(REQ_TEXT, 8'h00);
        push_word(REQ_PATTERN, 8'h7E);
        push_word(REQ_UNUSED, 8'hFF);
        push_word(REQ_CLEAR, 8'h00);
        push_word(REQ_PATTERN, 8'h80);
        push_word(REQ_TEXT, 8'h80);
        push_word(REQ_TEXT, 8'h01);
      end
      queue_random_runs(400);
      // Hold off until every word is out and every result is back
      do @(negedge clk);
      while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    end
    repeat (300) @(posedge clk);
    $display("Covered %0d words (%0d unused codes) over three idle profiles.",
             words_accepted, ignored_words);
    $display("Checked %0d results: %0d window matches, %0d rejected pattern bytes.",
             results_checked, match_count, reject_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_anagram_window_matcher passed");
    end else begin
      $display("tb_anagram_window_matcher failed");
    end
    $finish;
  end

endmodule
